FILE: design/seec_pkg.sv
package seec_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int PAGE_SIZE_DEF = 128;

  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 16;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

  localparam logic [BYTE_W-1:0] RST_READ_OPCODE   = 8'd3;
  localparam logic [BYTE_W-1:0] RST_STATUS_OPCODE = 8'd5;
  localparam logic [BYTE_W-1:0] RST_WREN_OPCODE   = 8'd6;
  localparam logic [BYTE_W-1:0] RST_WRITE_OPCODE  = 8'd2;
  localparam logic [BYTE_W-1:0] RST_UNLOCK_MASK   = 8'd2;

  typedef enum logic [1:0] {
    OP_DUPLEX   = 2'd0,
    OP_TX_ONLY  = 2'd1,
    OP_DESELECT = 2'd2
  } seec_op_t;

  typedef enum logic [2:0] {
    REG_READ_OP   = 3'd0,
    REG_STATUS_OP = 3'd1,
    REG_WREN_OP   = 3'd2,
    REG_WRITE_OP  = 3'd3,
    REG_UNLOCK    = 3'd4
  } seec_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_opcode;
    logic [BYTE_W-1:0] read_status_opcode;
    logic [BYTE_W-1:0] write_enable_opcode;
    logic [BYTE_W-1:0] write_opcode;
    logic [BYTE_W-1:0] unlock_bit_mask;
  } seec_cfg_t;

endpackage

FILE: design/seec_if.sv
interface seec_in_if
  import seec_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [BYTE_W-1:0] tx_byte;

  modport source (output valid, output operation, output tx_byte, input ready);
  modport sink (input valid, input operation, input tx_byte, output ready);
endinterface

interface seec_out_if
  import seec_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              rx_loaded;
  logic              tx_done;
  logic              rx_full;
  logic              tx_empty;

  modport source (output valid, output rx_byte, output rx_loaded, output tx_done,
                  output rx_full, output tx_empty, input ready);
  modport sink (input valid, input rx_byte, input rx_loaded, input tx_done,
                input rx_full, input tx_empty, output ready);
endinterface

FILE: design/seec_ram.sv
module seec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/seec_regs.sv
module seec_regs
  import seec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output seec_cfg_t         cfg
);

  seec_cfg_t cfg_r;
  seec_reg_t idx;
  logic      wr;

  assign pready = 1'b1;
  assign idx    = seec_reg_t'(paddr[CFG_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_opcode         <= RST_READ_OPCODE;
      cfg_r.read_status_opcode  <= RST_STATUS_OPCODE;
      cfg_r.write_enable_opcode <= RST_WREN_OPCODE;
      cfg_r.write_opcode        <= RST_WRITE_OPCODE;
      cfg_r.unlock_bit_mask     <= RST_UNLOCK_MASK;
    end else if (wr) begin
      case (idx)
        REG_READ_OP:   cfg_r.read_opcode         <= pwdata[BYTE_W-1:0];
        REG_STATUS_OP: cfg_r.read_status_opcode  <= pwdata[BYTE_W-1:0];
        REG_WREN_OP:   cfg_r.write_enable_opcode <= pwdata[BYTE_W-1:0];
        REG_WRITE_OP:  cfg_r.write_opcode        <= pwdata[BYTE_W-1:0];
        REG_UNLOCK:    cfg_r.unlock_bit_mask     <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_READ_OP:   prdata = CFG_DW'(cfg_r.read_opcode);
      REG_STATUS_OP: prdata = CFG_DW'(cfg_r.read_status_opcode);
      REG_WREN_OP:   prdata = CFG_DW'(cfg_r.write_enable_opcode);
      REG_WRITE_OP:  prdata = CFG_DW'(cfg_r.write_opcode);
      REG_UNLOCK:    prdata = CFG_DW'(cfg_r.unlock_bit_mask);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: design/spi_eeprom_command_engine_core.sv
// Serial EEPROM command engine, one SPI byte event per item and one result item per
// item. Sustains one item per clock unless the output stalls: each item makes at most
// one access to the byte memory (one read or one write port access), the memory
// registers its read data and the result passes the s1 register, then the output
// register. After reset the memory is swept to 0xFF, one byte a cycle, all 2**ADDR_BITS
// bytes (65536 by default); in_ch.ready stays low until the sweep ends, while register
// writes are taken at any time. Register i sits at byte address 4*i on the APB port.
module spi_eeprom_command_engine_core
  import seec_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int PAGE_SIZE = PAGE_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  seec_in_if.sink           in_ch,
  seec_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int MEM_DEPTH = 1 << ADDR_BITS;
  localparam int PAGE_W    = $clog2(PAGE_SIZE);
  localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_SIZE - 1);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_STATUS = 3'd1,
    PH_HIGH   = 3'd2,
    PH_LOW    = 3'd3,
    PH_DATA   = 3'd4
  } phase_t;

  typedef struct packed {
    logic              mem_sel;
    logic [BYTE_W-1:0] rx;
    logic              loaded;
    logic              tend;
    logic              rfull;
    logic              tempty;
  } res_t;

  seec_cfg_t cfg;

  seec_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  phase_t              phase_r, phase_nxt;
  logic [BYTE_W-1:0]   addr_high_r, addr_high_nxt;
  logic [BYTE_W-1:0]   addr_low_r, addr_low_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [PAGE_W-1:0]   page_ofs_r, page_ofs_nxt;
  logic [BYTE_W-1:0]   status_r, status_nxt;
  logic                clearing_r, clearing_nxt;
  logic [ADDR_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic                s1_valid_r, s1_valid_nxt;
  res_t                s1_r, s1_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_r, out_nxt;

  logic                in_fire, in_ready, s1_adv;
  logic [OFFSET_W-1:0] cur_sum;
  logic [ADDR_BITS-1:0] cur_addr;
  logic [PAGE_W-1:0]   page_inc;
  logic                item_we, item_re;
  logic                ram_we;
  logic [ADDR_BITS-1:0] ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic [BYTE_W-1:0]   ram_rdata;
  res_t                res_new;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !clearing_r && (!s1_valid_r || !out_valid_r || out_ch.ready);
  assign in_fire  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign cur_sum  = {addr_high_r, addr_low_r} + offset_r;
  assign cur_addr = cur_sum[ADDR_BITS-1:0];
  assign page_inc = (page_ofs_r == PAGE_LAST) ? '0 : page_ofs_r + 1'b1;

  assign ram_we    = clearing_r || item_we;
  assign ram_waddr = clearing_r ? clr_addr_r : cur_addr;
  assign ram_wdata = clearing_r ? ERASED_BYTE : in_ch.tx_byte;

  seec_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (item_re),
    .raddr (cur_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    phase_nxt     = phase_r;
    addr_high_nxt = addr_high_r;
    addr_low_nxt  = addr_low_r;
    offset_nxt    = offset_r;
    page_ofs_nxt  = page_ofs_r;
    status_nxt    = status_r;
    item_we       = 1'b0;
    item_re       = 1'b0;
    res_new       = '0;

    if (in_fire) begin
      case (seec_op_t'(in_ch.operation))
        OP_DUPLEX: begin
          res_new.rfull  = 1'b1;
          res_new.tempty = 1'b1;
          case (phase_r)
            PH_IDLE: begin
              if (in_ch.tx_byte == cfg.read_opcode) begin
                phase_nxt = PH_HIGH;
              end else if (in_ch.tx_byte == cfg.read_status_opcode) begin
                phase_nxt = PH_STATUS;
              end
            end
            PH_STATUS: begin
              res_new.rx     = status_r;
              res_new.loaded = 1'b1;
              res_new.tend   = 1'b1;
            end
            PH_HIGH: begin
              addr_high_nxt = in_ch.tx_byte;
              phase_nxt     = PH_LOW;
            end
            PH_LOW: begin
              addr_low_nxt = in_ch.tx_byte;
              phase_nxt    = PH_DATA;
            end
            default: begin
              item_re         = 1'b1;
              res_new.mem_sel = 1'b1;
              res_new.loaded  = 1'b1;
              res_new.tend    = 1'b1;
              offset_nxt      = offset_r + 1'b1;
              page_ofs_nxt    = (offset_r == '1) ? '0 : page_inc;
            end
          endcase
        end
        OP_TX_ONLY: begin
          res_new.tempty = 1'b1;
          case (phase_r)
            PH_IDLE: begin
              if (in_ch.tx_byte == cfg.write_enable_opcode) begin
                status_nxt   = status_r | cfg.unlock_bit_mask;
                res_new.tend = 1'b1;
              end else if (in_ch.tx_byte == cfg.write_opcode) begin
                phase_nxt = PH_HIGH;
              end
            end
            PH_STATUS: ;
            PH_HIGH: begin
              addr_high_nxt = in_ch.tx_byte;
              phase_nxt     = PH_LOW;
            end
            PH_LOW: begin
              addr_low_nxt = in_ch.tx_byte;
              phase_nxt    = PH_DATA;
            end
            default: begin
              item_we      = 1'b1;
              res_new.tend = 1'b1;
              offset_nxt   = OFFSET_W'(page_inc);
              page_ofs_nxt = page_inc;
            end
          endcase
        end
        OP_DESELECT: begin
          phase_nxt    = PH_IDLE;
          offset_nxt   = '0;
          page_ofs_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == '1) begin
        clearing_nxt = 1'b0;
      end
    end

    s1_nxt       = s1_r;
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_nxt       = res_new;
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_nxt       = s1_r;
      out_nxt.rx    = s1_r.mem_sel ? ram_rdata : s1_r.rx;
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      addr_high_r <= '0;
      addr_low_r  <= '0;
      offset_r    <= '0;
      page_ofs_r  <= '0;
      status_r    <= '0;
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      addr_high_r <= addr_high_nxt;
      addr_low_r  <= addr_low_nxt;
      offset_r    <= offset_nxt;
      page_ofs_r  <= page_ofs_nxt;
      status_r    <= status_nxt;
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s1_r  <= s1_nxt;
    out_r <= out_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.rx_byte   = out_r.rx;
  assign out_ch.rx_loaded = out_r.loaded;
  assign out_ch.tx_done   = out_r.tend;
  assign out_ch.rx_full   = out_r.rfull;
  assign out_ch.tx_empty  = out_r.tempty;

endmodule

FILE: design/seec_chk.sv
module seec_chk
  import seec_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] rx_byte,
  input logic              rx_loaded,
  input logic              tx_done,
  input logic              rx_full,
  input logic              tx_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(rx_byte) && $stable(rx_loaded)
      && $stable(tx_done) && $stable(rx_full) && $stable(tx_empty))
    else $error("result item changed while stalled");

  a_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !rx_loaded |-> rx_byte == '0)
    else $error("rx_byte nonzero without rx_loaded");

  a_loaded_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rx_loaded |-> tx_done && rx_full && tx_empty)
    else $error("loaded byte without full-duplex flags");

  a_tx_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tx_done && !rx_loaded |-> !rx_full && tx_empty)
    else $error("transmit end without load outside transmit-only item");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready && !out_valid)
    else $error("block not held off during memory sweep");

endmodule

bind spi_eeprom_command_engine_core seec_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .rx_byte   (out_ch.rx_byte),
  .rx_loaded (out_ch.rx_loaded),
  .tx_done   (out_ch.tx_done),
  .rx_full   (out_ch.rx_full),
  .tx_empty  (out_ch.tx_empty)
);
